### rtl/core/lcdc_pkg.sv
// shared types, codes and helpers of the character lcd text and cursor commander
package lcdc_pkg;

   localparam int COLUMNS = 16;
   localparam logic [3:0] LAST_COL = 4'(COLUMNS - 1);

   localparam int MAX_BYTES = 4;
   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam int IDX_W = $clog2(MAX_BYTES);

   localparam logic [2:0] OP_PUT_CHAR = 3'd0;
   localparam logic [2:0] OP_SET_COL  = 3'd1;
   localparam logic [2:0] OP_SET_ROW  = 3'd2;
   localparam logic [2:0] OP_SET_ADDR = 3'd3;
   localparam logic [2:0] OP_HOME     = 3'd4;
   localparam logic [2:0] OP_CLEAR    = 3'd5;

   localparam logic [7:0] CMD_SET_ADDR = 8'h80;
   localparam logic [7:0] CMD_CLEAR    = 8'h01;
   localparam logic [7:0] CMD_HOME     = 8'h02;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_BS    = 8'h08;

   typedef struct packed {
      logic       is_data;
      logic [7:0] lcd_byte;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0]          count;
      item_type [MAX_BYTES-1:0]  items;
      logic [6:0]                next_addr;
   } decode_type;

   function automatic item_type addr_item(input logic [6:0] addr);
      item_type it;
      it.is_data  = 1'b0;
      it.lcd_byte = CMD_SET_ADDR | {1'b0, addr};
      return it;
   endfunction

   function automatic item_type cmd_item(input logic [7:0] cmd);
      item_type it;
      it.is_data  = 1'b0;
      it.lcd_byte = cmd;
      return it;
   endfunction

   function automatic item_type data_item(input logic [7:0] ch);
      item_type it;
      it.is_data  = 1'b1;
      it.lcd_byte = ch;
      return it;
   endfunction

endpackage

### rtl/core/lcdc_if.sv
// valid/ready channel interfaces for requests and result bytes
interface lcdc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface lcdc_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] lcd_byte;
   logic       last;

   modport source (output valid, output is_data, output lcd_byte, output last, input ready);
   modport sink   (input valid, input is_data, input lcd_byte, input last, output ready);
endinterface

### rtl/core/lcdc_decode.sv
// turns one request and the cursor address into its byte sequence and next address
module lcdc_decode
   import lcdc_pkg::*;
(
   input  logic [2:0] op,
   input  logic [7:0] value,
   input  logic [6:0] addr,
   output decode_type dec
);

   logic [3:0] col;
   logic [6:0] bs_addr;
   logic [6:0] bs_wrap_addr;
   logic [6:0] wrap_addr;

   assign col          = addr[3:0];
   // backspace target: left one cell, or last column of the other row
   assign bs_addr      = (col == 4'd0) ? {~addr[6], addr[5:4], LAST_COL}
                                       : {addr[6:4], col - 4'd1};
   assign bs_wrap_addr = {~bs_addr[6], bs_addr[5:4], 4'd0};
   assign wrap_addr    = {~addr[6], addr[5:4], 4'd0};

   always_comb begin
      dec.count     = '0;
      dec.items     = '0;
      dec.next_addr = addr;
      case (op)
         OP_PUT_CHAR: begin
            if (value == CH_CR) begin
               dec.next_addr = {addr[6:4], 4'd0};
               dec.items[0]  = addr_item({addr[6:4], 4'd0});
               dec.count     = CNT_W'(1);
            end else if (value == CH_LF) begin
               dec.next_addr = {~addr[6], addr[5:0]};
               dec.items[0]  = addr_item({~addr[6], addr[5:0]});
               dec.count     = CNT_W'(1);
            end else if (value == CH_BS) begin
               dec.next_addr = bs_addr;
               dec.items[0]  = addr_item(bs_addr);
               dec.items[1]  = data_item(CH_SPACE);
               if (bs_addr[3:0] >= LAST_COL) begin
                  dec.items[2] = addr_item(bs_wrap_addr);
                  dec.items[3] = addr_item(bs_addr);
                  dec.count    = CNT_W'(4);
               end else begin
                  dec.items[2] = addr_item(bs_addr);
                  dec.count    = CNT_W'(3);
               end
            end else begin
               dec.items[0] = data_item(value);
               if (col >= LAST_COL) begin
                  dec.next_addr = wrap_addr;
                  dec.items[1]  = addr_item(wrap_addr);
                  dec.count     = CNT_W'(2);
               end else begin
                  dec.next_addr = {addr[6:4], col + 4'd1};
                  dec.count     = CNT_W'(1);
               end
            end
         end
         OP_SET_COL: begin
            dec.next_addr = {addr[6:4], value[3:0]};
            dec.items[0]  = addr_item({addr[6:4], value[3:0]});
            dec.count     = CNT_W'(1);
         end
         OP_SET_ROW: begin
            dec.next_addr = {value[0], addr[5:0]};
            dec.items[0]  = addr_item({value[0], addr[5:0]});
            dec.count     = CNT_W'(1);
         end
         OP_SET_ADDR: begin
            dec.next_addr = value[6:0];
            dec.items[0]  = addr_item(value[6:0]);
            dec.count     = CNT_W'(1);
         end
         OP_HOME: begin
            dec.next_addr = 7'd0;
            dec.items[0]  = cmd_item(CMD_HOME);
            dec.count     = CNT_W'(1);
         end
         OP_CLEAR: begin
            dec.next_addr = 7'd0;
            dec.items[0]  = cmd_item(CMD_CLEAR);
            dec.count     = CNT_W'(1);
         end
         default: begin
            dec.count = '0;
         end
      endcase
   end

endmodule

### rtl/core/char_lcd_text_cursor_commander.sv
// top level: request register, decode, and result byte serializer
// the first result byte is offered from the serializer register, which is loaded from
//   the request register once the serializer is free
// throughput: one request per cycle for requests of one byte while the result port
//   does not stall; a request that makes n bytes holds the result port for all n bytes, up to 4 (backspace)
// the result serializer sends one byte per cycle while the result port is ready and sets the sustained rate
// reset: synchronous, clears the cursor address to 0 and drops pending requests
module char_lcd_text_cursor_commander
   import lcdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lcdc_req_if.sink   req_ch,
   lcdc_rsp_if.source rsp_ch
);

   // request register
   logic       req_valid_ff, req_valid_in;
   logic [2:0] req_op_ff;
   logic [7:0] req_value_ff;

   // cursor address: column [3:0], block [5:4], row [6]
   logic [6:0] cursor_ff, cursor_in;

   // serializer holding the bytes of one request
   item_type [MAX_BYTES-1:0] ser_buf_ff;
   logic [CNT_W-1:0]         ser_cnt_ff, ser_cnt_in;
   logic [IDX_W-1:0]         ser_idx_ff, ser_idx_in;

   decode_type dec;
   logic       req_take;
   logic       rsp_take;
   logic       ser_last;
   logic       ser_free;
   logic       consume;
   logic       load;
   item_type   cur_item;

   lcdc_decode u_decode (
      .op    (req_op_ff),
      .value (req_value_ff),
      .addr  (cursor_ff),
      .dec   (dec)
   );

   // result port
   assign cur_item        = ser_buf_ff[ser_idx_ff];
   assign ser_last        = ({1'b0, ser_idx_ff} == CNT_W'(ser_cnt_ff - CNT_W'(1)));
   assign rsp_ch.valid    = (ser_cnt_ff != '0);
   assign rsp_ch.is_data  = cur_item.is_data;
   assign rsp_ch.lcd_byte = cur_item.lcd_byte;
   assign rsp_ch.last     = ser_last;
   assign rsp_take        = rsp_ch.valid && rsp_ch.ready;

   // serializer frees up when empty or when its last byte leaves this cycle
   assign ser_free = (ser_cnt_ff == '0) || (rsp_take && ser_last);
   // requests that make no bytes (unknown op) retire without the serializer
   assign consume  = req_valid_ff && ((dec.count == '0) || ser_free);
   assign load     = consume && (dec.count != '0);

   assign req_ch.ready = !req_valid_ff || consume;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (consume) begin
         req_valid_in = 1'b0;
      end
   end

   // cursor moves when the request hands its bytes over, keeping request order
   assign cursor_in = consume ? dec.next_addr : cursor_ff;

   always_comb begin
      ser_cnt_in = ser_cnt_ff;
      ser_idx_in = ser_idx_ff;
      if (load) begin
         ser_cnt_in = dec.count;
         ser_idx_in = '0;
      end else if (rsp_take) begin
         if (ser_last) begin
            ser_cnt_in = '0;
            ser_idx_in = '0;
         end else begin
            ser_idx_in = ser_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         cursor_ff    <= 7'd0;
         ser_cnt_ff   <= '0;
         ser_idx_ff   <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         cursor_ff    <= cursor_in;
         ser_cnt_ff   <= ser_cnt_in;
         ser_idx_ff   <= ser_idx_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_op_ff    <= req_ch.op;
         req_value_ff <= req_ch.value;
      end
      if (load) begin
         ser_buf_ff <= dec.items;
      end
   end

endmodule

### rtl/core/lcdc_checker.sv
// port level checks of the commander, bound to the top level
module lcdc_checker
   import lcdc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_data,
   input logic [7:0] rsp_lcd_byte,
   input logic       rsp_last
);

   // stalled result byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_is_data) && $stable(rsp_lcd_byte) && $stable(rsp_last)))
      else $error("result byte changed while stalled");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a sequence that is not finished keeps going without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("gap inside a byte sequence");

   // a data byte that is not last is followed by an address instruction
   a_data_then_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_is_data && !rsp_last) |=>
         (!rsp_is_data && rsp_lcd_byte[7]))
      else $error("data byte not followed by address instruction");

endmodule

bind char_lcd_text_cursor_commander lcdc_checker u_lcdc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_is_data  (rsp_ch.is_data),
   .rsp_lcd_byte (rsp_ch.lcd_byte),
   .rsp_last     (rsp_ch.last)
);
